// File: hw/rtl/dual_scan_gc_sequencer_unit_macros.svh
// Assertion macros for the sequencer modules; only dsgc_core uses them.
// The module that uses them must have ports named clk and arst_n.
`ifndef DUAL_SCAN_GC_SEQUENCER_UNIT_MACROS_SVH
`define DUAL_SCAN_GC_SEQUENCER_UNIT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define DSGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DSGC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/dsgc_pkg.sv
package dsgc_pkg;

	localparam int unsigned CMD_W   = 4;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned PHASE_W = 4;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned EV_W    = 3;

	localparam logic [CMD_W-1:0] CMD_START_BLOB = 4'd0;
	localparam logic [CMD_W-1:0] CMD_START_SNAP = 4'd1;
	localparam logic [CMD_W-1:0] CMD_DONE_BLOB  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DONE_SNAP  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DONE_CLEAN = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SHUTDOWN   = 4'd5;
	localparam logic [CMD_W-1:0] CMD_RESET      = 4'd6;
	localparam logic [CMD_W-1:0] CMD_FORCE      = 4'd7;
	localparam logic [CMD_W-1:0] CMD_QUERY      = 4'd8;

	localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INTERNAL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EXTERNAL = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK             = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_TRANSITION = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_MODE       = 2'd2;
	localparam logic [STAT_W-1:0] ST_MISMATCH       = 2'd3;

	localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_SHUTDOWN = 4'd10;
	localparam logic [PHASE_W-1:0] NO_MOVE     = 4'd15;

	localparam int unsigned NUM_PHASES = 11;
	localparam int unsigned NUM_EVENTS = 7;

	localparam logic [PHASE_W-1:0] NEXT_TBL [NUM_PHASES][NUM_EVENTS] = '{
		'{4'd1,  4'd2,  4'd15, 4'd15, 4'd15, 4'd10, 4'd0 },
		'{4'd15, 4'd3,  4'd4,  4'd15, 4'd15, 4'd10, 4'd15},
		'{4'd3,  4'd15, 4'd15, 4'd6,  4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd5,  4'd7,  4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd5,  4'd15, 4'd8,  4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd15, 4'd8,  4'd15, 4'd10, 4'd15},
		'{4'd7,  4'd15, 4'd8,  4'd15, 4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd8,  4'd15, 4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd15, 4'd15, 4'd9,  4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd10, 4'd0 },
		'{4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd0 }
	};

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [MODE_W-1:0]  scan_mode;
		logic [PHASE_W-1:0] forced_state;
	} cmd_item_t;

	typedef struct packed {
		logic [PHASE_W-1:0] state;
		logic [MODE_W-1:0]  mode_now;
		logic [STAT_W-1:0]  status;
	} res_item_t;

	// Out-of-range phases and events have no transition.
	function automatic logic [PHASE_W-1:0] lookup_next(input logic [PHASE_W-1:0] phase,
			input logic [EV_W-1:0] ev);
		logic [PHASE_W-1:0] r;
		r = NO_MOVE;
		if ((phase <= PH_SHUTDOWN) && (ev < EV_W'(NUM_EVENTS))) begin
			r = NEXT_TBL[phase][ev];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/dsgc_cmd_if.sv
interface dsgc_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [dsgc_pkg::CMD_W-1:0]   cmd;
	logic [dsgc_pkg::MODE_W-1:0]  scan_mode;
	logic [dsgc_pkg::PHASE_W-1:0] forced_state;

	modport source (output valid, output cmd, output scan_mode, output forced_state,
		input ready);
	modport sink (input valid, input cmd, input scan_mode, input forced_state,
		output ready);
endinterface

// File: hw/rtl/dsgc_res_if.sv
interface dsgc_res_if;
	logic                         valid;
	logic                         ready;
	logic [dsgc_pkg::PHASE_W-1:0] state;
	logic [dsgc_pkg::MODE_W-1:0]  mode_now;
	logic [dsgc_pkg::STAT_W-1:0]  status;

	modport source (output valid, output state, output mode_now, output status,
		input ready);
	modport sink (input valid, input state, input mode_now, input status,
		output ready);
endinterface

// File: hw/rtl/dsgc_in_reg.sv
module dsgc_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	dsgc_cmd_if.sink            req,
	input  logic                advance,
	output logic                valid_s1,
	output dsgc_pkg::cmd_item_t item_s1
);

	logic accept;

	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd          <= req.cmd;
			item_s1.scan_mode    <= req.scan_mode;
			item_s1.forced_state <= req.forced_state;
		end
	end

endmodule

// File: hw/rtl/dsgc_core.sv
`include "dual_scan_gc_sequencer_unit_macros.svh"

module dsgc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  dsgc_pkg::cmd_item_t item_s1,
	output dsgc_pkg::res_item_t res
);

	logic [dsgc_pkg::PHASE_W-1:0] state_q;
	logic [dsgc_pkg::MODE_W-1:0]  mode_q;
	logic [dsgc_pkg::PHASE_W-1:0] nxt_phase;
	logic [dsgc_pkg::MODE_W-1:0]  nxt_mode;
	logic [dsgc_pkg::STAT_W-1:0]  nxt_status;
	logic [dsgc_pkg::PHASE_W-1:0] lk;

	assign lk = dsgc_pkg::lookup_next(state_q, item_s1.cmd[dsgc_pkg::EV_W-1:0]);

	always_comb begin
		nxt_phase  = state_q;
		nxt_mode   = mode_q;
		nxt_status = dsgc_pkg::ST_OK;
		priority if (item_s1.cmd == dsgc_pkg::CMD_QUERY) begin
			nxt_status = dsgc_pkg::ST_OK;
		end else if (item_s1.cmd == dsgc_pkg::CMD_FORCE) begin
			if (item_s1.forced_state <= dsgc_pkg::PH_SHUTDOWN) begin
				nxt_phase = item_s1.forced_state;
			end else begin
				nxt_status = dsgc_pkg::ST_BAD_TRANSITION;
			end
		end else if (item_s1.cmd > dsgc_pkg::CMD_RESET) begin
			nxt_status = dsgc_pkg::ST_BAD_TRANSITION;
		end else if ((item_s1.cmd == dsgc_pkg::CMD_START_SNAP)
				&& (item_s1.scan_mode != dsgc_pkg::MODE_INTERNAL)
				&& (item_s1.scan_mode != dsgc_pkg::MODE_EXTERNAL)) begin
			nxt_status = dsgc_pkg::ST_BAD_MODE;
		end else if (lk == dsgc_pkg::NO_MOVE) begin
			nxt_status = dsgc_pkg::ST_BAD_TRANSITION;
		end else if ((item_s1.cmd == dsgc_pkg::CMD_DONE_SNAP)
				&& (item_s1.scan_mode != mode_q)) begin
			nxt_status = dsgc_pkg::ST_MISMATCH;
		end else begin
			nxt_phase = lk;
			if (item_s1.cmd == dsgc_pkg::CMD_START_SNAP) begin
				nxt_mode = item_s1.scan_mode;
			end else if ((item_s1.cmd == dsgc_pkg::CMD_DONE_SNAP)
					|| (item_s1.cmd == dsgc_pkg::CMD_RESET)) begin
				nxt_mode = dsgc_pkg::MODE_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsgc_pkg::PH_IDLE;
			mode_q  <= dsgc_pkg::MODE_NONE;
		end else if (fire) begin
			state_q <= nxt_phase;
			mode_q  <= nxt_mode;
		end
	end

	assign res.state    = nxt_phase;
	assign res.mode_now = nxt_mode;
	assign res.status   = nxt_status;

	`DSGC_ASSERT(a_hold_when_idle, !fire |=> $stable(state_q) && $stable(mode_q), "state moved without a word")
	`DSGC_ASSERT(a_reject_keeps, fire && (nxt_status != dsgc_pkg::ST_OK) |=> (state_q == $past(state_q)) && (mode_q == $past(mode_q)), "rejected word changed state")
	`DSGC_ASSERT_ALWAYS(a_mode_legal, mode_q != 2'd3, "recorded mode holds an unused code")

endmodule

// File: hw/rtl/dsgc_out_reg.sv
module dsgc_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  dsgc_pkg::res_item_t res,
	output logic                free,
	dsgc_res_if.source          rsp
);

	logic                valid_q;
	dsgc_pkg::res_item_t item_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= res;
		end
	end

	assign rsp.valid    = valid_q;
	assign rsp.state    = item_q.state;
	assign rsp.mode_now = item_q.mode_now;
	assign rsp.status   = item_q.status;

endmodule

// File: hw/rtl/dual_scan_gc_sequencer_unit.sv
// A word accepted on the command side goes through the input register, then the result register.
// Throughput: one word per cycle while results are taken; the input register and the result
// register both advance whenever the result register is empty or its word is being taken.
// Reset (arst_n low) sets the phase to idle, the recorded mode to none and empties both
// registers.
module dual_scan_gc_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	dsgc_cmd_if.sink    req,
	dsgc_res_if.source  rsp
);

	logic                valid_s1;
	logic                free;
	logic                fire;
	dsgc_pkg::cmd_item_t item_s1;
	dsgc_pkg::res_item_t res;

	assign fire = valid_s1 && free;

	dsgc_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.advance  (free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dsgc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.res     (res)
	);

	dsgc_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.res    (res),
		.free   (free),
		.rsp    (rsp)
	);

endmodule

// File: sim/testbench.sv
module testbench;
	import dsgc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_WORDS   = 550;
	localparam int unsigned DRAIN_CYCLES   = 6;

	// Allowed moves per phase and event; 15 marks a move that does not exist.
	localparam logic [PHASE_W-1:0] PHASE_MOVES [NUM_PHASES][NUM_EVENTS] = '{
		'{4'd1,  4'd2,  4'd15, 4'd15, 4'd15, 4'd10, 4'd0 },
		'{4'd15, 4'd3,  4'd4,  4'd15, 4'd15, 4'd10, 4'd15},
		'{4'd3,  4'd15, 4'd15, 4'd6,  4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd5,  4'd7,  4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd5,  4'd15, 4'd8,  4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd15, 4'd8,  4'd15, 4'd10, 4'd15},
		'{4'd7,  4'd15, 4'd8,  4'd15, 4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd8,  4'd15, 4'd15, 4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd15, 4'd15, 4'd9,  4'd10, 4'd15},
		'{4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd10, 4'd0 },
		'{4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd0 }
	};

	logic clk;
	logic arst_n;

	dsgc_cmd_if req_if();
	dsgc_res_if rsp_if();

	dual_scan_gc_sequencer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	cmd_item_t cmd_backlog [$];
	res_item_t awaited_reports [$];
	cmd_item_t next_word;
	res_item_t oldest_report;

	logic [PHASE_W-1:0] model_phase = PH_IDLE;
	logic [MODE_W-1:0]  model_mode  = MODE_NONE;

	int error_count = 0;
	int words_taken = 0;
	int total_words = 0;
	int burst_left  = 1;
	int gap_left    = 0;
	int idle_cycles = 0;
	int stall_span  = 0;
	logic [7:0] stall_bits = 8'hFF;
	logic [2:0] stall_pos  = 3'd0;

	always #1 clk = ~clk;

	function automatic res_item_t advance_phase(input cmd_item_t w);
		res_item_t r;
		logic [PHASE_W-1:0] nxt;
		r.status = ST_OK;
		if (w.cmd == CMD_QUERY) begin
			r.status = ST_OK;
		end else if (w.cmd == CMD_FORCE) begin
			if (w.forced_state <= PH_SHUTDOWN)
				model_phase = w.forced_state;
			else
				r.status = ST_BAD_TRANSITION;
		end else if (w.cmd > CMD_RESET) begin
			r.status = ST_BAD_TRANSITION;
		end else if (w.cmd == CMD_START_SNAP && w.scan_mode != MODE_INTERNAL
				&& w.scan_mode != MODE_EXTERNAL) begin
			r.status = ST_BAD_MODE;
		end else begin
			nxt = (model_phase <= PH_SHUTDOWN) ? PHASE_MOVES[model_phase][w.cmd[EV_W-1:0]]
				: NO_MOVE;
			if (nxt == NO_MOVE) begin
				r.status = ST_BAD_TRANSITION;
			end else if (w.cmd == CMD_DONE_SNAP && w.scan_mode != model_mode) begin
				r.status = ST_MISMATCH;
			end else begin
				model_phase = nxt;
				if (w.cmd == CMD_START_SNAP)
					model_mode = w.scan_mode;
				else if (w.cmd == CMD_DONE_SNAP || w.cmd == CMD_RESET)
					model_mode = MODE_NONE;
			end
		end
		r.state = model_phase;
		r.mode_now = model_mode;
		return r;
	endfunction

	task automatic queue_word(input logic [CMD_W-1:0] c, input logic [MODE_W-1:0] m,
			input logic [PHASE_W-1:0] f);
		cmd_item_t w;
		w.cmd = c;
		w.scan_mode = m;
		w.forced_state = f;
		cmd_backlog.push_back(w);
	endtask

	// One pass through both scans in a random interleaving, then cleanup.
	// Some passes are cut short, carry a wrong completion mode or a shutdown.
	task automatic queue_scan_pass();
		logic [MODE_W-1:0] m;
		int blob_step;
		int snap_step;
		int steps;
		int cut_at;
		blob_step = 0;
		snap_step = 0;
		steps = 0;
		cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 99;
		m = $urandom_range(0, 1) ? MODE_EXTERNAL : MODE_INTERNAL;
		if ($urandom_range(0, 3) == 0)
			queue_word(CMD_FORCE, 2'($urandom), PH_IDLE);
		else
			queue_word(CMD_RESET, 2'($urandom), 4'($urandom));
		while ((blob_step < 2 || snap_step < 2) && steps < cut_at) begin
			if (snap_step == 2 || (blob_step < 2 && $urandom_range(0, 1) == 1)) begin
				queue_word(blob_step == 0 ? CMD_START_BLOB : CMD_DONE_BLOB,
					2'($urandom), 4'($urandom));
				blob_step++;
			end else if (snap_step == 0) begin
				queue_word(CMD_START_SNAP, m, 4'($urandom));
				snap_step++;
			end else begin
				if ($urandom_range(0, 7) == 0)
					queue_word(CMD_DONE_SNAP, m ^ 2'b11, 4'($urandom));
				queue_word(CMD_DONE_SNAP, m, 4'($urandom));
				snap_step++;
			end
			if ($urandom_range(0, 9) == 0)
				queue_word(CMD_QUERY, 2'($urandom), 4'($urandom));
			steps++;
		end
		if ($urandom_range(0, 9) == 0)
			queue_word(CMD_SHUTDOWN, 2'($urandom), 4'($urandom));
		queue_word(CMD_DONE_CLEAN, 2'($urandom), 4'($urandom));
	endtask

	task automatic queue_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			queue_word(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
				2'($urandom),
				$urandom_range(0, 1) ? 4'($urandom_range(0, 10)) : 4'($urandom));
		end
	endtask

	task automatic report_field(input string name, input logic [3:0] want,
			input logic [3:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.cmd <= CMD_QUERY;
			req_if.scan_mode <= MODE_NONE;
			req_if.forced_state <= PH_IDLE;
		end else begin
			if (req_if.valid && req_if.ready) begin
				awaited_reports.push_back(advance_phase({req_if.cmd, req_if.scan_mode,
					req_if.forced_state}));
				words_taken <= words_taken + 1;
			end
			if (!req_if.valid || req_if.ready) begin
				if (gap_left != 0) begin
					req_if.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (cmd_backlog.size() != 0) begin
					next_word = cmd_backlog.pop_front();
					req_if.cmd <= next_word.cmd;
					req_if.scan_mode <= next_word.scan_mode;
					req_if.forced_state <= next_word.forced_state;
					req_if.valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (awaited_reports.size() == 0) begin
					$display("%0t: unexpected result word, expected none, %s %0d %0d %0d",
						$time, "actual state mode status", rsp_if.state, rsp_if.mode_now,
						rsp_if.status);
					error_count++;
				end else begin
					oldest_report = awaited_reports.pop_front();
					report_field("state", oldest_report.state, rsp_if.state);
					report_field("mode_now", 4'(oldest_report.mode_now), 4'(rsp_if.mode_now));
					report_field("status", 4'(oldest_report.status), 4'(rsp_if.status));
				end
			end
			rsp_if.ready <= stall_bits[stall_pos];
			stall_pos <= stall_pos + 3'd1;
			if (stall_span == 63) begin
				stall_span <= 0;
				stall_bits <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
			end else begin
				stall_span <= stall_span + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int random_base;
		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_QUERY;
		req_if.scan_mode = MODE_NONE;
		req_if.forced_state = PH_IDLE;
		rsp_if.ready = 1'b1;

		queue_word(CMD_QUERY, MODE_NONE, PH_IDLE);
		queue_word(CMD_START_SNAP, MODE_NONE, PH_IDLE);
		queue_word(CMD_START_SNAP, 2'd3, 4'd15);
		queue_word(CMD_DONE_BLOB, MODE_NONE, PH_IDLE);
		queue_word(CMD_DONE_CLEAN, MODE_NONE, PH_IDLE);
		queue_word(4'd9, MODE_NONE, PH_IDLE);
		queue_word(4'd15, 2'd3, 4'd15);
		queue_word(CMD_FORCE, MODE_NONE, 4'd11);
		queue_word(CMD_FORCE, 2'd3, 4'd15);
		queue_word(CMD_START_BLOB, MODE_NONE, PH_IDLE);
		queue_word(CMD_START_SNAP, MODE_EXTERNAL, PH_IDLE);
		queue_word(CMD_DONE_SNAP, MODE_INTERNAL, PH_IDLE);
		queue_word(CMD_DONE_SNAP, MODE_EXTERNAL, PH_IDLE);
		queue_word(CMD_DONE_BLOB, MODE_NONE, PH_IDLE);
		queue_word(CMD_DONE_CLEAN, MODE_NONE, PH_IDLE);
		queue_word(CMD_RESET, MODE_NONE, PH_IDLE);
		queue_word(CMD_START_SNAP, MODE_INTERNAL, PH_IDLE);
		queue_word(CMD_SHUTDOWN, MODE_NONE, PH_IDLE);
		queue_word(CMD_START_SNAP, MODE_EXTERNAL, PH_IDLE);
		queue_word(CMD_DONE_SNAP, MODE_EXTERNAL, PH_IDLE);
		queue_word(CMD_FORCE, MODE_NONE, 4'd4);
		queue_word(CMD_START_SNAP, MODE_INTERNAL, PH_IDLE);
		queue_word(CMD_FORCE, MODE_NONE, PH_SHUTDOWN);
		queue_word(CMD_RESET, MODE_NONE, PH_IDLE);
		queue_word(CMD_FORCE, MODE_NONE, 4'd9);
		queue_word(CMD_RESET, MODE_NONE, PH_IDLE);

		random_base = cmd_backlog.size();
		while (cmd_backlog.size() - random_base < RANDOM_WORDS) begin
			if ($urandom_range(0, 3) == 0)
				queue_noise();
			else
				queue_scan_pass();
		end
		total_words = cmd_backlog.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken < total_words || awaited_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/dsgc_pkg.sv
hw/rtl/dsgc_cmd_if.sv
hw/rtl/dsgc_res_if.sv
hw/rtl/dsgc_in_reg.sv
hw/rtl/dsgc_core.sv
hw/rtl/dsgc_out_reg.sv
hw/rtl/dual_scan_gc_sequencer_unit.sv
sim/testbench.sv
